// ===== hdl/mafsm_pkg.sv =====
// Shared types, state codes, register indexes and constants of the moisture alarm mode machine.
package mafsm_pkg;

    // Default width of the ADC readings.
    localparam int ADC_BITS_DEF = 10;

    // Alarm state codes.
    localparam logic [2:0] ST_INITIAL    = 3'd0;
    localparam logic [2:0] ST_HIBERNATE  = 3'd1;
    localparam logic [2:0] ST_ALERT      = 3'd2;
    localparam logic [2:0] ST_VERY_ALERT = 3'd3;
    localparam logic [2:0] ST_PANIC      = 3'd4;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_LIGHT_THRESHOLD    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BATTERY_FULL_LEVEL = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HIBERNATE_SLEEPS   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ALERT_SLEEPS       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_VERY_ALERT_SLEEPS  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PANIC_SLEEPS       = 3'd5;
    localparam int CFG_DATA_W = 16;

    // Hysteresis thresholds on the moisture difference.
    localparam int TH_DRY     = 2;
    localparam int TH_DAMP    = 5;
    localparam int TH_WET     = 10;
    localparam int TH_SOAKED  = 20;

    // Battery margins above the full-battery reference reading.
    localparam int BATT_LOW_MARGIN   = 5;
    localparam int BATT_EMPTY_MARGIN = 61;

    // Register reset values.
    localparam logic [15:0] LIGHT_THRESHOLD_RST   = 16'd65530;
    localparam logic [15:0] HIBERNATE_SLEEPS_RST  = 16'd450;
    localparam logic [15:0] ALERT_SLEEPS_RST      = 16'd37;
    localparam logic [15:0] VERY_ALERT_SLEEPS_RST = 16'd2;
    localparam logic [15:0] PANIC_SLEEPS_RST      = 16'd1;

    // Light threshold and sleep counts handed to the step logic.
    typedef struct packed {
        logic [15:0] light_threshold;
        logic [15:0] hibernate_sleeps;
        logic [15:0] alert_sleeps;
        logic [15:0] very_alert_sleeps;
        logic [15:0] panic_sleeps;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic [2:0]  alarm_state;
        logic        long_interval;
        logic [15:0] sleep_count;
        logic        play_happy;
        logic        chirp_alarm;
        logic        blink_led;
        logic        battery_low;
        logic        battery_empty;
    } t_result;

endpackage

// ===== hdl/mafsm_step.sv =====
// Combinational next-state and result logic for one measurement.
module mafsm_step #(
    parameter int ADC_BITS = mafsm_pkg::ADC_BITS_DEF
) (
    input  logic [2:0]          i_state,
    input  logic [ADC_BITS-1:0] i_ref_level,
    input  logic [ADC_BITS-1:0] i_capacitance,
    input  logic [15:0]         i_light_count,
    input  logic [ADC_BITS-1:0] i_ref_voltage,
    input  logic [ADC_BITS-1:0] i_battery_full_level,
    input  mafsm_pkg::t_cfg     i_cfg,
    output logic [2:0]          o_state,
    output logic [ADC_BITS-1:0] o_ref_level,
    output mafsm_pkg::t_result  o_result
);

    localparam int DW = ADC_BITS + 1;
    localparam logic signed [DW-1:0] D_DRY    = DW'(mafsm_pkg::TH_DRY);
    localparam logic signed [DW-1:0] D_DAMP   = DW'(mafsm_pkg::TH_DAMP);
    localparam logic signed [DW-1:0] D_WET    = DW'(mafsm_pkg::TH_WET);
    localparam logic signed [DW-1:0] D_SOAKED = DW'(mafsm_pkg::TH_SOAKED);
    localparam logic [DW-1:0] LOW_MARGIN   = DW'(mafsm_pkg::BATT_LOW_MARGIN);
    localparam logic [DW-1:0] EMPTY_MARGIN = DW'(mafsm_pkg::BATT_EMPTY_MARGIN);

    logic [ADC_BITS-1:0]  ref_eff;
    logic signed [DW-1:0] diff;
    logic [2:0]           st;
    logic                 happy;
    logic [DW-1:0]        full_ext;
    logic [DW-1:0]        refv_ext;
    logic                 awake;
    logic                 is_light;

    // Latch the first capacitance as the reference while it is still zero.
    assign ref_eff     = (i_ref_level == '0) ? i_capacitance : i_ref_level;
    assign o_ref_level = ref_eff;
    assign diff        = $signed({1'b0, i_capacitance}) - $signed({1'b0, ref_eff});

    // Alarm state transitions with hysteresis.
    always_comb begin
        st    = i_state;
        happy = 1'b0;
        case (i_state)
            mafsm_pkg::ST_PANIC: begin
                if (diff > D_WET) begin
                    happy = 1'b1;
                    st    = mafsm_pkg::ST_HIBERNATE;
                end else if (diff > D_DRY) begin
                    st = mafsm_pkg::ST_VERY_ALERT;
                end
            end
            mafsm_pkg::ST_VERY_ALERT: begin
                if (diff > D_WET) begin
                    happy = 1'b1;
                    st    = mafsm_pkg::ST_HIBERNATE;
                end else if (diff <= D_DRY) begin
                    st = mafsm_pkg::ST_PANIC;
                end else if (diff > D_DAMP) begin
                    st = mafsm_pkg::ST_ALERT;
                end
            end
            mafsm_pkg::ST_ALERT: begin
                happy = (diff > D_SOAKED);
                if (diff <= D_DAMP) begin
                    st = mafsm_pkg::ST_VERY_ALERT;
                end else if (diff > D_WET) begin
                    st = mafsm_pkg::ST_HIBERNATE;
                end
            end
            mafsm_pkg::ST_HIBERNATE: begin
                if (diff <= D_WET) begin
                    st = mafsm_pkg::ST_ALERT;
                end
            end
            default: begin
                st = mafsm_pkg::ST_PANIC;
            end
        endcase
    end

    assign o_state = st;

    // Battery flags: the reference reading rises as the battery drops.
    assign full_ext = {1'b0, i_battery_full_level};
    assign refv_ext = {1'b0, i_ref_voltage};
    assign awake    = (st != mafsm_pkg::ST_HIBERNATE);
    assign is_light = (i_light_count < i_cfg.light_threshold);

    // Assemble the result for the new state.
    always_comb begin
        o_result.alarm_state   = st;
        o_result.long_interval = (st != mafsm_pkg::ST_PANIC);
        case (st)
            mafsm_pkg::ST_HIBERNATE:  o_result.sleep_count = i_cfg.hibernate_sleeps;
            mafsm_pkg::ST_ALERT:      o_result.sleep_count = i_cfg.alert_sleeps;
            mafsm_pkg::ST_VERY_ALERT: o_result.sleep_count = i_cfg.very_alert_sleeps;
            default:                  o_result.sleep_count = i_cfg.panic_sleeps;
        endcase
        o_result.play_happy    = happy;
        o_result.chirp_alarm   = awake && is_light;
        o_result.blink_led     = awake && !is_light;
        o_result.battery_low   = refv_ext > (full_ext + LOW_MARGIN);
        o_result.battery_empty = refv_ext > (full_ext + EMPTY_MARGIN);
    end

endmodule

// ===== hdl/moisture_alarm_mode_fsm.sv =====
// Top level of the moisture alarm mode machine: registers, handshakes and result buffering.
// An accepted request goes into the result register, or into the skid stage behind a stalled
// result. Throughput: one request per cycle while the skid stage is empty, set by the single
// pass of compare logic between state and result registers; input acceptance is registered.
// Reset (synchronous, active low) puts the machine in its initial state, clears the reference
// level and both buffer stages, and loads the configuration registers with their defaults.
module moisture_alarm_mode_fsm #(
    parameter int ADC_BITS = mafsm_pkg::ADC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [ADC_BITS-1:0]               i_capacitance,
    input  logic [15:0]                       i_light_count,
    input  logic [ADC_BITS-1:0]               i_ref_voltage,
    // Result channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [2:0]                        o_alarm_state,
    output logic                              o_long_interval,
    output logic [15:0]                       o_sleep_count,
    output logic                              o_play_happy,
    output logic                              o_chirp_alarm,
    output logic                              o_blink_led,
    output logic                              o_battery_low,
    output logic                              o_battery_empty,
    // Configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mafsm_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [mafsm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    mafsm_pkg::t_cfg     r_cfg;
    logic [ADC_BITS-1:0] r_battery_full_level;
    logic [2:0]          r_state;
    logic [ADC_BITS-1:0] r_ref_level;
    logic [2:0]          n_state;
    logic [ADC_BITS-1:0] n_ref_level;
    mafsm_pkg::t_result  n_result;
    mafsm_pkg::t_result  r_out;
    mafsm_pkg::t_result  r_skid;
    logic                r_out_valid;
    logic                r_skid_valid;
    logic                in_fire;
    logic                cfg_fire;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign o_stall     = r_skid_valid;
    assign in_fire     = i_valid && !r_skid_valid;

    // Configuration registers; writes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.light_threshold   <= mafsm_pkg::LIGHT_THRESHOLD_RST;
            r_cfg.hibernate_sleeps  <= mafsm_pkg::HIBERNATE_SLEEPS_RST;
            r_cfg.alert_sleeps      <= mafsm_pkg::ALERT_SLEEPS_RST;
            r_cfg.very_alert_sleeps <= mafsm_pkg::VERY_ALERT_SLEEPS_RST;
            r_cfg.panic_sleeps      <= mafsm_pkg::PANIC_SLEEPS_RST;
            r_battery_full_level    <= '0;
        end else if (cfg_fire) begin
            case (i_cfg_index)
                mafsm_pkg::REG_LIGHT_THRESHOLD:    r_cfg.light_threshold   <= i_cfg_data;
                mafsm_pkg::REG_BATTERY_FULL_LEVEL: r_battery_full_level    <=
                    i_cfg_data[ADC_BITS-1:0];
                mafsm_pkg::REG_HIBERNATE_SLEEPS:   r_cfg.hibernate_sleeps  <= i_cfg_data;
                mafsm_pkg::REG_ALERT_SLEEPS:       r_cfg.alert_sleeps      <= i_cfg_data;
                mafsm_pkg::REG_VERY_ALERT_SLEEPS:  r_cfg.very_alert_sleeps <= i_cfg_data;
                mafsm_pkg::REG_PANIC_SLEEPS:       r_cfg.panic_sleeps      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Next state and result for the request on the input ports.
    mafsm_step #(
        .ADC_BITS(ADC_BITS)
    ) u_step (
        .i_state             (r_state),
        .i_ref_level         (r_ref_level),
        .i_capacitance       (i_capacitance),
        .i_light_count       (i_light_count),
        .i_ref_voltage       (i_ref_voltage),
        .i_battery_full_level(r_battery_full_level),
        .i_cfg               (r_cfg),
        .o_state             (n_state),
        .o_ref_level         (n_ref_level),
        .o_result            (n_result)
    );

    // Machine state advances on every accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mafsm_pkg::ST_INITIAL;
            r_ref_level <= '0;
        end else if (in_fire) begin
            r_state     <= n_state;
            r_ref_level <= n_ref_level;
        end
    end

    // Result register with a skid stage behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (!i_stall) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (in_fire) begin
            if (r_out_valid && i_stall) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payloads.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (!i_stall) begin
                r_out <= r_skid;
            end
        end else if (in_fire) begin
            if (r_out_valid && i_stall) begin
                r_skid <= n_result;
            end else begin
                r_out <= n_result;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_alarm_state   = r_out.alarm_state;
    assign o_long_interval = r_out.long_interval;
    assign o_sleep_count   = r_out.sleep_count;
    assign o_play_happy    = r_out.play_happy;
    assign o_chirp_alarm   = r_out.chirp_alarm;
    assign o_blink_led     = r_out.blink_led;
    assign o_battery_low   = r_out.battery_low;
    assign o_battery_empty = r_out.battery_empty;

    // The machine never rests in its initial state once a request has passed.
    a_left_initial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_state != mafsm_pkg::ST_INITIAL)
        else $error("alarm state is initial after an accepted request");

    // The skid stage only fills behind a held result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a result while the output register is empty");

    // A latched reference is kept.
    a_ref_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ref_level != '0 |=> $stable(r_ref_level))
        else $error("reference level changed after it was latched");

    // Chirp and blink are exclusive, and both are off in hibernate.
    a_chirp_blink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_chirp_alarm && o_blink_led)
            && ((o_alarm_state == mafsm_pkg::ST_HIBERNATE) == !(o_chirp_alarm || o_blink_led)))
        else $error("chirp and blink flags disagree with the alarm state");

    // An empty battery is also a low one.
    a_battery_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_battery_empty |-> o_battery_low)
        else $error("battery empty without battery low");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the moisture alarm mode machine: directed table, then random phases.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // Run shape.
    localparam int PHASES        = 15;
    localparam int PER_PHASE     = 50;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 400000;

    // Hysteresis thresholds on the moisture difference and battery margins.
    localparam int DRY_LIMIT    = 2;
    localparam int DAMP_LIMIT   = 5;
    localparam int WET_LIMIT    = 10;
    localparam int SOAKED_LIMIT = 20;
    localparam int LOW_MARGIN   = 5;
    localparam int EMPTY_MARGIN = 61;

    // Register indexes past the end of the list; writes to them must be ignored.
    localparam logic [mafsm_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [mafsm_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

    // One line of the directed table: a register write or a moisture reading.
    typedef struct packed {
        bit                 is_write;
        logic [2:0]         idx;
        logic [15:0]        wdata;
        logic [9:0]         cap;
        logic [15:0]        light;
        logic [9:0]         refv;
        bit                 pinned;
        mafsm_pkg::t_result want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [9:0]  i_capacitance = '0;
    logic [15:0] i_light_count = '0;
    logic [9:0]  i_ref_voltage = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_alarm_state;
    logic        o_long_interval;
    logic [15:0] o_sleep_count;
    logic        o_play_happy;
    logic        o_chirp_alarm;
    logic        o_blink_led;
    logic        o_battery_low;
    logic        o_battery_empty;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [mafsm_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [mafsm_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    // Predictor copy of the alarm machine and its registers.
    logic [2:0]  alarm_now = mafsm_pkg::ST_INITIAL;
    logic [9:0]  soil_ref = '0;
    logic [15:0] light_thr = 16'd65530;
    logic [9:0]  full_level = '0;
    logic [15:0] hib_sleeps = 16'd450;
    logic [15:0] alert_sleeps = 16'd37;
    logic [15:0] vigil_sleeps = 16'd2;
    logic [15:0] panic_sleeps = 16'd1;

    // Alarms still owed by the block, oldest first.
    mafsm_pkg::t_result alarm_due[$];
    t_row               plan[$];

    // A pinned expectation travels with the request that is being offered.
    bit                 pin_valid = 1'b0;
    mafsm_pkg::t_result pin_result = '0;

    bit       calm = 1'b0;
    int       faults = 0;
    int       readings_sent = 0;
    int       alarms_checked = 0;
    int       reg_writes = 0;
    int       tunes_heard = 0;
    int       cycle_count = 0;
    bit [7:0] states_seen = '0;

    moisture_alarm_mode_fsm u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_capacitance   (i_capacitance),
        .i_light_count   (i_light_count),
        .i_ref_voltage   (i_ref_voltage),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_alarm_state   (o_alarm_state),
        .o_long_interval (o_long_interval),
        .o_sleep_count   (o_sleep_count),
        .o_play_happy    (o_play_happy),
        .o_chirp_alarm   (o_chirp_alarm),
        .o_blink_led     (o_blink_led),
        .o_battery_low   (o_battery_low),
        .o_battery_empty (o_battery_empty),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 100 MHz clock.
    always #5 i_clk = ~i_clk;

    // Works out the alarm for one reading and advances the predictor state.
    function automatic mafsm_pkg::t_result predict_alarm(input logic [9:0] cap,
                                                         input logic [15:0] light,
                                                         input logic [9:0] refv);
        mafsm_pkg::t_result r;
        int                 d;
        logic [2:0]         nxt;
        logic               happy;
        logic               awake;
        nxt   = alarm_now;
        happy = 1'b0;
        if (soil_ref == '0) begin
            soil_ref = cap;
        end
        d = int'(cap) - int'(soil_ref);
        case (alarm_now)
            mafsm_pkg::ST_PANIC: begin
                if (d > WET_LIMIT) begin
                    happy = 1'b1;
                    nxt   = mafsm_pkg::ST_HIBERNATE;
                end else if (d > DRY_LIMIT) begin
                    nxt = mafsm_pkg::ST_VERY_ALERT;
                end
            end
            mafsm_pkg::ST_VERY_ALERT: begin
                if (d > WET_LIMIT) begin
                    happy = 1'b1;
                    nxt   = mafsm_pkg::ST_HIBERNATE;
                end else if (d <= DRY_LIMIT) begin
                    nxt = mafsm_pkg::ST_PANIC;
                end else if (d > DAMP_LIMIT) begin
                    nxt = mafsm_pkg::ST_ALERT;
                end
            end
            mafsm_pkg::ST_ALERT: begin
                happy = (d > SOAKED_LIMIT);
                if (d <= DAMP_LIMIT) begin
                    nxt = mafsm_pkg::ST_VERY_ALERT;
                end else if (d > WET_LIMIT) begin
                    nxt = mafsm_pkg::ST_HIBERNATE;
                end
            end
            mafsm_pkg::ST_HIBERNATE: begin
                if (d <= WET_LIMIT) begin
                    nxt = mafsm_pkg::ST_ALERT;
                end
            end
            default: begin
                nxt = mafsm_pkg::ST_PANIC;
            end
        endcase
        alarm_now = nxt;

        r.alarm_state   = nxt;
        r.long_interval = (nxt != mafsm_pkg::ST_PANIC);
        case (nxt)
            mafsm_pkg::ST_HIBERNATE:  r.sleep_count = hib_sleeps;
            mafsm_pkg::ST_ALERT:      r.sleep_count = alert_sleeps;
            mafsm_pkg::ST_VERY_ALERT: r.sleep_count = vigil_sleeps;
            default:                  r.sleep_count = panic_sleeps;
        endcase
        r.play_happy    = happy;
        awake           = (nxt != mafsm_pkg::ST_HIBERNATE);
        r.chirp_alarm   = awake && (light < light_thr);
        r.blink_led     = awake && !(light < light_thr);
        r.battery_low   = (int'(refv) - int'(full_level)) > LOW_MARGIN;
        r.battery_empty = (int'(refv) - int'(full_level)) > EMPTY_MARGIN;
        return r;
    endfunction

    function automatic t_row write_row(input logic [2:0] idx, input logic [15:0] data);
        t_row r;
        r          = '0;
        r.is_write = 1'b1;
        r.idx      = idx;
        r.wdata    = data;
        return r;
    endfunction

    function automatic t_row reading_row(input logic [9:0] cap, input logic [15:0] light,
                                         input logic [9:0] refv);
        t_row r;
        r       = '0;
        r.cap   = cap;
        r.light = light;
        r.refv  = refv;
        return r;
    endfunction

    // A reading whose alarm is written out by hand.
    function automatic t_row pinned_row(input logic [9:0] cap, input logic [15:0] light,
                                        input logic [9:0] refv, input mafsm_pkg::t_result want);
        t_row r;
        r        = reading_row(cap, light, refv);
        r.pinned = 1'b1;
        r.want   = want;
        return r;
    endfunction

    function automatic int clip(input int v, input int hi);
        return (v < 0) ? 0 : (v > hi) ? hi : v;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            faults++;
        end
    endtask

    // Offers one reading and holds it until the block takes the request.
    task automatic send_reading(input logic [9:0] cap, input logic [15:0] light,
                                input logic [9:0] refv, input bit pinned,
                                input mafsm_pkg::t_result want);
        i_valid       <= 1'b1;
        i_capacitance <= cap;
        i_light_count <= light;
        i_ref_voltage <= refv;
        pin_valid     <= pinned;
        pin_result    <= want;
        do @(posedge i_clk); while (o_stall);
        readings_sent++;
    endtask

    // Leaves the write channel high; the caller lowers it after the last write.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Stops offering readings and waits until every owed alarm has come back.
    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (alarm_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Result side stall: random bursts, either stalled or open; none once calm.
    initial begin : result_stall
        int unsigned n;
        bit          stalled;
        forever begin
            n       = $urandom_range(1, 17);
            stalled = ($urandom_range(0, 2) == 0);
            repeat (n) begin
                i_stall <= stalled && !calm;
                @(posedge i_clk);
            end
        end
    end

    // Compares each accepted alarm with the oldest one owed, and tracks the predictor.
    always @(posedge i_clk) begin : scoreboard
        mafsm_pkg::t_result got;
        mafsm_pkg::t_result want;
        mafsm_pkg::t_result model;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = {o_alarm_state, o_long_interval, o_sleep_count, o_play_happy,
                       o_chirp_alarm, o_blink_led, o_battery_low, o_battery_empty};
                if (alarm_due.size() == 0) begin
                    $display("%0t: alarm with none expected, got state %0d sleeps %0d",
                             $time, got.alarm_state, got.sleep_count);
                    faults++;
                end else begin
                    want = alarm_due.pop_front();
                    check_field("alarm_state", 16'(want.alarm_state), 16'(got.alarm_state));
                    check_field("long_interval", 16'(want.long_interval),
                                16'(got.long_interval));
                    check_field("sleep_count", want.sleep_count, got.sleep_count);
                    check_field("play_happy", 16'(want.play_happy), 16'(got.play_happy));
                    check_field("chirp_alarm", 16'(want.chirp_alarm), 16'(got.chirp_alarm));
                    check_field("blink_led", 16'(want.blink_led), 16'(got.blink_led));
                    check_field("battery_low", 16'(want.battery_low), 16'(got.battery_low));
                    check_field("battery_empty", 16'(want.battery_empty),
                                16'(got.battery_empty));
                    alarms_checked++;
                    if (!$isunknown(got.alarm_state)) begin
                        states_seen[got.alarm_state] = 1'b1;
                    end
                    if (got.play_happy === 1'b1) begin
                        tunes_heard++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                model = predict_alarm(i_capacitance, i_light_count, i_ref_voltage);
                alarm_due.push_back(pin_valid ? pin_result : model);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                reg_writes++;
                case (i_cfg_index)
                    mafsm_pkg::REG_LIGHT_THRESHOLD:    light_thr    = i_cfg_data;
                    mafsm_pkg::REG_BATTERY_FULL_LEVEL: full_level   = i_cfg_data[9:0];
                    mafsm_pkg::REG_HIBERNATE_SLEEPS:   hib_sleeps   = i_cfg_data;
                    mafsm_pkg::REG_ALERT_SLEEPS:       alert_sleeps = i_cfg_data;
                    mafsm_pkg::REG_VERY_ALERT_SLEEPS:  vigil_sleeps = i_cfg_data;
                    mafsm_pkg::REG_PANIC_SLEEPS:       panic_sleeps = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Hard stop should the block hang.
    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timed out after %0d cycles", $time, cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stimulus
        t_row        row;
        logic [9:0]  cap;
        logic [9:0]  refv;
        logic [15:0] light;
        logic [15:0] val;
        logic [2:0]  idx;
        int          writes;
        int          pick;
        bit          gaps_on;
        bit          last_was_write;

        // Fields of the pinned alarms: state, long interval, sleeps, tune, chirp, blink,
        // battery low, battery empty.
        // Zero capacitance leaves the reference at zero; the first move is always to panic.
        plan.push_back(pinned_row(10'd0, 16'h0000, 10'd0,
                       {mafsm_pkg::ST_PANIC, 1'b0, 16'd1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}));
        plan.push_back(pinned_row(10'd0, 16'hFFFF, 10'h3FF,
                       {mafsm_pkg::ST_PANIC, 1'b0, 16'd1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1}));
        // The reference latches at 500; battery low sits just on its margin.
        plan.push_back(pinned_row(10'd500, 16'd65529, 10'd5,
                       {mafsm_pkg::ST_PANIC, 1'b0, 16'd1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}));
        plan.push_back(reading_row(10'd503, 16'h0000, 10'd6));
        // Registers at one set of extremes; the battery level write carries stray high bits.
        plan.push_back(write_row(mafsm_pkg::REG_LIGHT_THRESHOLD, 16'h0000));
        plan.push_back(write_row(mafsm_pkg::REG_BATTERY_FULL_LEVEL, 16'hFFFF));
        plan.push_back(write_row(mafsm_pkg::REG_HIBERNATE_SLEEPS, 16'hFFFF));
        plan.push_back(write_row(mafsm_pkg::REG_ALERT_SLEEPS, 16'd1));
        plan.push_back(write_row(mafsm_pkg::REG_VERY_ALERT_SLEEPS, 16'hFFFF));
        plan.push_back(write_row(mafsm_pkg::REG_PANIC_SLEEPS, 16'hFFFF));
        plan.push_back(write_row(REG_SPARE_A, 16'h1234));
        plan.push_back(write_row(REG_SPARE_B, 16'hFFFF));
        plan.push_back(pinned_row(10'd506, 16'h0000, 10'h3FF,
                       {mafsm_pkg::ST_ALERT, 1'b1, 16'd1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}));
        plan.push_back(reading_row(10'd505, 16'h0000, 10'd0));
        plan.push_back(reading_row(10'd502, 16'hFFFF, 10'd512));
        // The opposite extremes.
        plan.push_back(write_row(mafsm_pkg::REG_LIGHT_THRESHOLD, 16'hFFFF));
        plan.push_back(write_row(mafsm_pkg::REG_BATTERY_FULL_LEVEL, 16'h0000));
        plan.push_back(write_row(mafsm_pkg::REG_HIBERNATE_SLEEPS, 16'd1));
        plan.push_back(write_row(mafsm_pkg::REG_ALERT_SLEEPS, 16'hFFFF));
        plan.push_back(write_row(mafsm_pkg::REG_VERY_ALERT_SLEEPS, 16'd1));
        plan.push_back(write_row(mafsm_pkg::REG_PANIC_SLEEPS, 16'd1));
        plan.push_back(pinned_row(10'd511, 16'd65534, 10'd62,
                       {mafsm_pkg::ST_HIBERNATE, 1'b1, 16'd1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1}));
        plan.push_back(pinned_row(10'd510, 16'hFFFF, 10'd61,
                       {mafsm_pkg::ST_ALERT, 1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}));
        // Walk transitions among hibernate, alert and very alert around their thresholds.
        plan.push_back(reading_row(10'd521, 16'd100, 10'd20));
        plan.push_back(reading_row(10'd515, 16'd100, 10'd20));
        plan.push_back(reading_row(10'd510, 16'd100, 10'd20));
        plan.push_back(reading_row(10'd520, 16'd100, 10'd20));
        plan.push_back(reading_row(10'd505, 16'd100, 10'd20));
        plan.push_back(reading_row(10'd508, 16'd100, 10'd20));
        plan.push_back(reading_row(10'd505, 16'd100, 10'd20));
        plan.push_back(reading_row(10'd511, 16'd100, 10'd20));
        // Large negative differences, then the widest positive one.
        plan.push_back(reading_row(10'd0, 16'd7, 10'd70));
        plan.push_back(reading_row(10'd0, 16'd7, 10'd70));
        plan.push_back(reading_row(10'd0, 16'd7, 10'd70));
        plan.push_back(reading_row(10'h3FF, 16'd7, 10'd70));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table; writes only go in once the block has drained.
        last_was_write = 1'b0;
        foreach (plan[i]) begin
            row = plan[i];
            if (row.is_write) begin
                if (!last_was_write) begin
                    settle();
                end
                write_reg(row.idx, row.wdata);
            end else begin
                if (last_was_write) begin
                    i_cfg_valid <= 1'b0;
                end
                send_reading(row.cap, row.light, row.refv, row.pinned, row.want);
            end
            last_was_write = row.is_write;
        end

        // Random phases: a few register writes, then readings mostly near the thresholds.
        for (int p = 0; p < PHASES; p++) begin
            settle();
            writes = $urandom_range(1, 4);
            for (int w = 0; w < writes; w++) begin
                idx  = 3'($urandom_range(0, 7));
                pick = $urandom_range(0, 3);
                case (idx)
                    mafsm_pkg::REG_LIGHT_THRESHOLD: begin
                        val = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
                    end
                    mafsm_pkg::REG_BATTERY_FULL_LEVEL: begin
                        val = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'h03FF : 16'($urandom);
                    end
                    mafsm_pkg::REG_HIBERNATE_SLEEPS, mafsm_pkg::REG_ALERT_SLEEPS,
                    mafsm_pkg::REG_VERY_ALERT_SLEEPS, mafsm_pkg::REG_PANIC_SLEEPS: begin
                        val = (pick == 0) ? 16'd1 : (pick == 1) ? 16'hFFFF :
                              16'($urandom_range(1, 65535));
                    end
                    default: begin
                        val = 16'($urandom);
                    end
                endcase
                write_reg(idx, val);
            end
            i_cfg_valid <= 1'b0;
            calm    = (p == PHASES - 1);
            gaps_on = !calm && ($urandom_range(0, 3) != 0);

            for (int k = 0; k < PER_PHASE; k++) begin
                if (gaps_on && $urandom_range(0, 4) == 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 17)) @(posedge i_clk);
                end
                case ($urandom_range(0, 9))
                    0: cap = 10'($urandom);
                    1: cap = ($urandom_range(0, 1) == 0) ? 10'd0 : 10'h3FF;
                    default: cap = 10'(clip(int'(soil_ref) + int'($urandom_range(0, 50)) - 25,
                                            1023));
                endcase
                case ($urandom_range(0, 3))
                    0: light = 16'($urandom);
                    1: light = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
                    default: light = 16'(clip(int'(light_thr) + int'($urandom_range(0, 6)) - 3,
                                              65535));
                endcase
                if ($urandom_range(0, 3) == 0) begin
                    refv = 10'($urandom);
                end else begin
                    refv = 10'(clip(int'(full_level) + int'($urandom_range(0, 70)) - 4, 1023));
                end
                send_reading(cap, light, refv, 1'b0, '0);
            end
        end

        // Drain what is still owed, then give the block time to show anything extra.
        i_valid <= 1'b0;
        do @(posedge i_clk); while (alarm_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Moisture readings sent: %0d, alarms checked: %0d, register writes: %0d.",
                 readings_sent, alarms_checked, reg_writes);
        $display("Alarm states reached (one bit per code): %b; watered tune played %0d times.",
                 states_seen, tunes_heard);
        if (faults == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== moisture_alarm_mode_fsm.f =====
hdl/mafsm_pkg.sv
hdl/mafsm_step.sv
hdl/moisture_alarm_mode_fsm.sv
dv/tb_top.sv
